### sv/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// concurrent assertion on the block clock and reset
`define DWL_ASSERT(lbl, prop, msg) `ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

### sv/dwl_pkg.sv
// shared types and constants of the word graph lookup block
`default_nettype none
package dwl_pkg;

   localparam int MODE_W     = 3;
   localparam int TOTAL_W    = 13;
   localparam int COUNT_W    = 9;
   localparam int CHAR_W     = 8;
   localparam int TARGET_W   = 12;
   localparam int WALK_W     = 13;

   localparam logic [MODE_W-1:0] MODE_BEGIN  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_VERTEX = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ARC    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EMPTY  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VDATA,
      ST_SCAN,
      ST_FDATA,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic run;
   } scan_ctrl_type;

   typedef struct packed {
      logic                hit;
      logic                miss;
      logic [TARGET_W-1:0] target;
   } scan_stat_type;

endpackage
`default_nettype wire

### sv/dwl_if.sv
// request and response channel interfaces
`default_nettype none
interface dwl_req_if;
   import dwl_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [TOTAL_W-1:0]  vertex_total;
   logic                vertex_is_final;
   logic [COUNT_W-1:0]  vertex_arc_count;
   logic [CHAR_W-1:0]   arc_letter;
   logic [TARGET_W-1:0] arc_target;
   logic [CHAR_W-1:0]   letter;
   logic                word_end;
   modport source (output valid, mode, vertex_total, vertex_is_final, vertex_arc_count,
                   arc_letter, arc_target, letter, word_end, input ready);
   modport sink (input valid, mode, vertex_total, vertex_is_final, vertex_arc_count,
                 arc_letter, arc_target, letter, word_end, output ready);
endinterface

interface dwl_rsp_if;
   logic valid;
   logic ready;
   logic word_found;
   modport source (output valid, word_found, input ready);
   modport sink (input valid, word_found, output ready);
endinterface
`default_nettype wire

### sv/dwl_vtx_ram.sv
// vertex table memory: final flag, first arc index and arc count per vertex
`default_nettype none
module dwl_vtx_ram #(
   parameter int VERTEX_DEPTH = 4096,
   parameter int ARC_DEPTH    = 8192
) (
   input  wire                                  clock,
   input  wire                                  wr_en,
   input  wire  [$clog2(VERTEX_DEPTH)-1:0]      wr_addr,
   input  wire                                  wr_final,
   input  wire  [$clog2(ARC_DEPTH+1)-1:0]       wr_first,
   input  wire  [dwl_pkg::COUNT_W-1:0]          wr_count,
   input  wire  [$clog2(VERTEX_DEPTH)-1:0]      rd_addr,
   output logic                                 rd_final,
   output logic [$clog2(ARC_DEPTH+1)-1:0]       rd_first,
   output logic [dwl_pkg::COUNT_W-1:0]          rd_count
);
   import dwl_pkg::*;

   localparam int APW = $clog2(ARC_DEPTH + 1);

   typedef struct packed {
      logic               final_flag;
      logic [APW-1:0]     first;
      logic [COUNT_W-1:0] count;
   } vtx_rec_type;

   vtx_rec_type mem [VERTEX_DEPTH];
   vtx_rec_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{final_flag: wr_final, first: wr_first, count: wr_count};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_final = rd_ff.final_flag;
   assign rd_first = rd_ff.first;
   assign rd_count = rd_ff.count;

endmodule
`default_nettype wire

### sv/dwl_arc_scan.sv
// arc table and the shared scan unit: one arc read and one letter compare per cycle
`default_nettype none
module dwl_arc_scan #(
   parameter int ARC_DEPTH   = 8192,
   parameter int LETTER_BITS = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  dwl_pkg::scan_ctrl_type               ctrl,
   input  wire  [$clog2(ARC_DEPTH+1)-1:0]       base,
   input  wire  [dwl_pkg::COUNT_W-1:0]          count,
   input  wire  [LETTER_BITS-1:0]               letter,
   input  wire                                  wr_en,
   input  wire  [$clog2(ARC_DEPTH)-1:0]         wr_addr,
   input  wire  [LETTER_BITS-1:0]               wr_label,
   input  wire  [dwl_pkg::TARGET_W-1:0]         wr_target,
   output dwl_pkg::scan_stat_type               stat
);
   import dwl_pkg::*;

   localparam int AW  = $clog2(ARC_DEPTH);
   localparam int APW = $clog2(ARC_DEPTH + 1);

   typedef struct packed {
      logic [LETTER_BITS-1:0] label;
      logic [TARGET_W-1:0]    target;
   } arc_rec_type;

   arc_rec_type        mem [ARC_DEPTH];
   arc_rec_type        rd_ff;
   logic [APW-1:0]     addr_ff, addr_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic               pend_ff, pend_in;
   logic               can_issue;
   logic               match;
   logic               issue;

   // more arcs of this vertex left and still inside the table
   assign can_issue = (left_ff != '0) && (addr_ff < APW'(ARC_DEPTH));
   assign match     = pend_ff && (rd_ff.label == letter);
   assign issue     = ctrl.run && !match && can_issue;

   always_comb begin
      addr_in = addr_ff;
      left_in = left_ff;
      pend_in = pend_ff;
      priority if (ctrl.start) begin
         addr_in = base;
         left_in = count;
         pend_in = 1'b0;
      end else if (issue) begin
         addr_in = addr_ff + APW'(1);
         left_in = left_ff - COUNT_W'(1);
         pend_in = 1'b1;
      end else if (ctrl.run) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      addr_ff <= addr_in;
      left_ff <= left_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{label: wr_label, target: wr_target};
      end
      if (issue) begin
         rd_ff <= mem[addr_ff[AW-1:0]];
      end
   end

   assign stat.hit    = ctrl.run && match;
   assign stat.miss   = ctrl.run && !match && !can_issue;
   assign stat.target = rd_ff.target;

endmodule
`default_nettype wire

### sv/dawg_word_lookup.sv
// top level of the word graph lookup: load sequencing, walk state and response register
`default_nettype none
`include "assert_macros.svh"
// usage
//   req_bus carries one transaction per item: begin load, vertex, arc, query letter
//   or empty word query, selected by mode. rsp_bus returns word_found, one transaction
//   on each query letter with word_end set and on each empty word query.
// load
//   begin, vertex and arc loads leave the block idle with req_bus.ready high, so loads
//   stream at one per cycle unless a query is at work; loads past capacity are dropped.
// query
//   a query letter on a live walk goes through a vertex table read, then the shared
//   scan unit reads and compares one arc per cycle until a hit or until the vertex
//   has no arcs left. the word end adds a final-flag read before its response. an
//   empty word query reads only the root's final flag. ready is low while a query
//   is at work.
// reset
//   synchronous, active high: clears the graph size, load pointers, walk and the
//   response register. the tables are not cleared and need no sweep.
// stall
//   the response sits in an output register; loads keep flowing under a stall, and a
//   second response waits in its final state until rsp_bus.ready drains the first.
module dawg_word_lookup #(
   parameter int VERTEX_DEPTH = 4096,
   parameter int ARC_DEPTH    = 8192,
   parameter int LETTER_BITS  = 8
) (
   input  wire           clock,
   input  wire           reset,
   dwl_req_if.sink       req_bus,
   dwl_rsp_if.source     rsp_bus
);
   import dwl_pkg::*;

   localparam int VW   = $clog2(VERTEX_DEPTH);
   localparam int VCW  = $clog2(VERTEX_DEPTH + 1);
   localparam int AW   = $clog2(ARC_DEPTH);
   localparam int APW  = $clog2(ARC_DEPTH + 1);
   localparam int SUMW = ((APW > COUNT_W) ? APW : COUNT_W) + 1;

   state_type              state_ff, state_in;
   logic [VCW-1:0]         vig_ff, vig_in;        // vertices in graph
   logic [VCW-1:0]         vlp_ff, vlp_in;        // vertex load pointer
   logic [APW-1:0]         alp_ff, alp_in;        // arc load pointer
   logic [APW-1:0]         ofs_ff, ofs_in;        // running arc layout offset
   logic [WALK_W-1:0]      walk_v_ff, walk_v_in;
   logic                   walk_started_ff, walk_started_in;
   logic                   walk_dead_ff, walk_dead_in;
   logic [LETTER_BITS-1:0] letter_ff, letter_in;
   logic                   word_end_ff, word_end_in;
   logic                   fin_ok_ff, fin_ok_in;  // final flag read is meaningful
   logic                   result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;

   logic                   accept;
   logic                   out_free;
   logic [WALK_W-1:0]      eff_v;
   logic                   eff_dead;
   logic                   eff_in_range;
   logic                   qdead;
   logic                   tgt_in_range;
   logic [SUMW-1:0]        ofs_sum;

   // table ports
   logic                   vwr_en;
   logic [VW-1:0]          vrd_addr;
   logic                   vrd_final;
   logic [APW-1:0]         vrd_first;
   logic [COUNT_W-1:0]     vrd_count;
   logic                   awr_en;
   scan_ctrl_type          scan_ctrl;
   scan_stat_type          scan_stat;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // vertex the next letter steps from; the root when no walk is under way
   assign eff_v        = walk_started_ff ? walk_v_ff : WALK_W'(vig_ff - VCW'(1));
   assign eff_dead     = walk_started_ff ? walk_dead_ff : (vig_ff == '0);
   assign eff_in_range = 32'(eff_v) < 32'(VERTEX_DEPTH);
   // a vertex past the table has no arcs, so the walk dies there
   assign qdead        = eff_dead || !eff_in_range;
   assign tgt_in_range = 32'(scan_stat.target) < 32'(VERTEX_DEPTH);
   assign ofs_sum      = SUMW'(ofs_ff) + SUMW'(req_bus.vertex_arc_count);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_bus.mode == MODE_QUERY) begin
                  if (!qdead) begin
                     state_in = ST_VDATA;
                  end else if (req_bus.word_end) begin
                     state_in = ST_FDATA;
                  end
               end else if (req_bus.mode == MODE_EMPTY) begin
                  state_in = ST_FDATA;
               end
            end
         end
         ST_VDATA: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_stat.hit || scan_stat.miss) begin
               state_in = word_end_ff ? ST_FDATA : ST_IDLE;
            end
         end
         ST_FDATA: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_bus.ready   = (state_ff == ST_IDLE);
      scan_ctrl.start = (state_ff == ST_VDATA);
      scan_ctrl.run   = (state_ff == ST_SCAN);
      vwr_en          = accept && (req_bus.mode == MODE_VERTEX)
                        && (vlp_ff < VCW'(VERTEX_DEPTH));
      awr_en          = accept && (req_bus.mode == MODE_ARC)
                        && (alp_ff < APW'(ARC_DEPTH));
      // vertex table read: root for empty word, walk vertex for a letter, arc target
      // for the final flag at a word end
      unique case (state_ff)
         ST_SCAN: vrd_addr = VW'(scan_stat.target);
         default: begin
            if (req_bus.mode == MODE_EMPTY) begin
               vrd_addr = VW'(vig_ff - VCW'(1));
            end else begin
               vrd_addr = VW'(eff_v);
            end
         end
      endcase
   end

   // datapath next values
   always_comb begin
      vig_in          = vig_ff;
      vlp_in          = vlp_ff;
      alp_in          = alp_ff;
      ofs_in          = ofs_ff;
      walk_v_in       = walk_v_ff;
      walk_started_in = walk_started_ff;
      walk_dead_in    = walk_dead_ff;
      letter_in       = letter_ff;
      word_end_in     = word_end_ff;
      fin_ok_in       = fin_ok_ff;
      result_in       = result_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_found_in    = rsp_found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_bus.mode)
                  MODE_BEGIN: begin
                     if (32'(req_bus.vertex_total) > 32'(VERTEX_DEPTH)) begin
                        vig_in = VCW'(VERTEX_DEPTH);
                     end else begin
                        vig_in = VCW'(req_bus.vertex_total);
                     end
                     vlp_in          = '0;
                     alp_in          = '0;
                     ofs_in          = '0;
                     walk_v_in       = '0;
                     walk_started_in = 1'b0;
                     walk_dead_in    = 1'b0;
                  end
                  MODE_VERTEX: begin
                     if (vwr_en) begin
                        vlp_in = vlp_ff + VCW'(1);
                        if (ofs_sum > SUMW'(ARC_DEPTH)) begin
                           ofs_in = APW'(ARC_DEPTH);
                        end else begin
                           ofs_in = APW'(ofs_sum);
                        end
                     end
                  end
                  MODE_ARC: begin
                     if (awr_en) begin
                        alp_in = alp_ff + APW'(1);
                     end
                  end
                  MODE_QUERY: begin
                     walk_started_in = 1'b1;
                     walk_v_in       = eff_v;
                     walk_dead_in    = qdead;
                     letter_in       = LETTER_BITS'(req_bus.letter);
                     word_end_in     = req_bus.word_end;
                     fin_ok_in       = 1'b0;
                     if (qdead && req_bus.word_end) begin
                        walk_v_in       = '0;
                        walk_started_in = 1'b0;
                        walk_dead_in    = 1'b0;
                     end
                  end
                  MODE_EMPTY: begin
                     walk_v_in       = '0;
                     walk_started_in = 1'b0;
                     walk_dead_in    = 1'b0;
                     fin_ok_in       = (vig_ff != '0);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            priority if (scan_stat.hit) begin
               walk_v_in = WALK_W'(scan_stat.target);
               fin_ok_in = tgt_in_range;
            end else if (scan_stat.miss) begin
               walk_dead_in = 1'b1;
               fin_ok_in    = 1'b0;
            end
            if ((scan_stat.hit || scan_stat.miss) && word_end_ff) begin
               walk_v_in       = '0;
               walk_started_in = 1'b0;
               walk_dead_in    = 1'b0;
            end
         end
         ST_FDATA: result_in = fin_ok_ff && vrd_final;
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = result_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vig_ff          <= '0;
         vlp_ff          <= '0;
         alp_ff          <= '0;
         ofs_ff          <= '0;
         walk_v_ff       <= '0;
         walk_started_ff <= 1'b0;
         walk_dead_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vig_ff          <= vig_in;
         vlp_ff          <= vlp_in;
         alp_ff          <= alp_in;
         ofs_ff          <= ofs_in;
         walk_v_ff       <= walk_v_in;
         walk_started_ff <= walk_started_in;
         walk_dead_ff    <= walk_dead_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      letter_ff    <= letter_in;
      word_end_ff  <= word_end_in;
      fin_ok_ff    <= fin_ok_in;
      result_ff    <= result_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.word_found = rsp_found_ff;

   // vertex table
   dwl_vtx_ram #(
      .VERTEX_DEPTH (VERTEX_DEPTH),
      .ARC_DEPTH    (ARC_DEPTH)
   ) u_vtx_ram (
      .clock    (clock),
      .wr_en    (vwr_en),
      .wr_addr  (vlp_ff[VW-1:0]),
      .wr_final (req_bus.vertex_is_final),
      .wr_first (ofs_ff),
      .wr_count (req_bus.vertex_arc_count),
      .rd_addr  (vrd_addr),
      .rd_final (vrd_final),
      .rd_first (vrd_first),
      .rd_count (vrd_count)
   );

   // arc table and scan unit
   dwl_arc_scan #(
      .ARC_DEPTH   (ARC_DEPTH),
      .LETTER_BITS (LETTER_BITS)
   ) u_arc_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .base      (vrd_first),
      .count     (vrd_count),
      .letter    (letter_ff),
      .wr_en     (awr_en),
      .wr_addr   (alp_ff[AW-1:0]),
      .wr_label  (LETTER_BITS'(req_bus.arc_letter)),
      .wr_target (req_bus.arc_target),
      .stat      (scan_stat)
   );

   `DWL_ASSERT(a_scan_excl, !(scan_stat.hit && scan_stat.miss), "scan hit and miss at once")
   `DWL_ASSERT(a_dead_started, walk_dead_ff |-> walk_started_ff, "dead walk never started")
   `DWL_ASSERT(a_ptr_bound, (32'(alp_ff) <= 32'(ARC_DEPTH)) && (32'(vlp_ff) <= 32'(VERTEX_DEPTH)), "load pointer past capacity")
   `DWL_ASSERT(a_resp_load, (state_ff == ST_RESP && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE), "response not loaded")

endmodule
`default_nettype wire

### tb/dawg_word_lookup_tb.sv
// testbench for the word graph lookup: directed table, table-capacity fill, random graphs and words
module dawg_word_lookup_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dwl_pkg::*;

   localparam int VDEPTH       = 4096;
   localparam int ADEPTH       = 8192;
   localparam int LBITS        = 8;
   localparam int IDLE_LIMIT   = 5000;  // cycles with no transaction on either channel
   localparam int DRAIN_CYCLES = 300;   // settle time before the verdict
   localparam int PHASE_ITEMS  = 290;   // counted items per idling phase
   localparam int DIR_N        = 24;

   // modes the block must ignore
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   // one request transaction, all fields driven on every transaction
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [TOTAL_W-1:0]  vertex_total;
      logic                vertex_is_final;
      logic [COUNT_W-1:0]  vertex_arc_count;
      logic [CHAR_W-1:0]   arc_letter;
      logic [TARGET_W-1:0] arc_target;
      logic [CHAR_W-1:0]   letter;
      logic                word_end;
   } lookup_req_t;

   typedef enum bit {CHK_PREDICT, CHK_FIXED} check_kind_t;

   // directed row: arguments are interpreted per mode
   //   begin: arg0 = vertex total; vertex: arg0 = final, arg1 = arc count
   //   arc: arg0 = letter, arg1 = target; query: arg0 = letter, arg1 = word end
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [12:0]       arg0;
      logic [11:0]       arg1;
      check_kind_t       chk;
      bit                exp;
   } dir_row_t;

   logic clock;
   logic reset;

   dwl_req_if req_if ();
   dwl_rsp_if rsp_if ();

   dawg_word_lookup #(
      .VERTEX_DEPTH (VDEPTH),
      .ARC_DEPTH    (ADEPTH),
      .LETTER_BITS  (LBITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // graph image kept by the testbench, plus which entries were ever written
   bit                vtx_final   [VDEPTH];
   int unsigned       vtx_first   [VDEPTH];
   bit [COUNT_W-1:0]  vtx_count   [VDEPTH];
   bit                vtx_written [VDEPTH];
   bit [CHAR_W-1:0]   arc_label   [ADEPTH];
   bit [TARGET_W-1:0] arc_dest    [ADEPTH];
   bit                arc_written [ADEPTH];
   int unsigned       graph_size;
   int unsigned       vtx_ptr;
   int unsigned       arc_ptr;
   int unsigned       arc_offset;
   int unsigned       walk_vertex;
   bit                walk_started;
   bit                walk_dead;

   bit          pending_found [$];  // expected word_found values, oldest first
   dir_row_t    dir_tab [DIR_N];
   int unsigned src_idle;           // percent of cycles the sender idles
   int unsigned snk_stall;          // percent of cycles the receiver stalls
   int unsigned items_sent;
   int unsigned errors;
   int unsigned idle_cycles;

   // free-running clock, 20 ns period
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // advance the graph image by one transaction; with commit clear only the outcome is
   // worked out, and clean tells whether every table entry read had been written
   function automatic void graph_step(input lookup_req_t it, input bit commit,
                                      output bit has_rsp, output bit found, output bit clean);
      int unsigned v, nxt, base, i;
      bit          started, dead, hit;
      v = walk_vertex;
      started = walk_started;
      dead = walk_dead;
      has_rsp = 1'b0;
      found = 1'b0;
      clean = 1'b1;
      case (it.mode)
         MODE_BEGIN: begin
            if (commit) begin
               graph_size = (it.vertex_total > VDEPTH) ? VDEPTH : it.vertex_total;
               vtx_ptr = 0;
               arc_ptr = 0;
               arc_offset = 0;
            end
            v = 0;
            started = 1'b0;
            dead = 1'b0;
         end
         MODE_VERTEX: begin
            if (commit && vtx_ptr < VDEPTH) begin
               vtx_final[vtx_ptr] = it.vertex_is_final;
               vtx_first[vtx_ptr] = arc_offset;
               vtx_count[vtx_ptr] = it.vertex_arc_count;
               vtx_written[vtx_ptr] = 1'b1;
               vtx_ptr++;
               arc_offset += it.vertex_arc_count;
               if (arc_offset > ADEPTH) arc_offset = ADEPTH;
            end
         end
         MODE_ARC: begin
            if (commit && arc_ptr < ADEPTH) begin
               arc_label[arc_ptr] = it.arc_letter;
               arc_dest[arc_ptr] = it.arc_target;
               arc_written[arc_ptr] = 1'b1;
               arc_ptr++;
            end
         end
         MODE_QUERY: begin
            // first letter of a word starts at the root, the last vertex of the graph size
            if (!started) begin
               started = 1'b1;
               dead = (graph_size == 0);
               v = dead ? 0 : graph_size - 1;
            end
            if (!dead) begin
               hit = 1'b0;
               nxt = 0;
               if (!vtx_written[v]) clean = 1'b0;
               base = vtx_first[v];
               // arcs at or past the arc table end are never looked at
               for (i = 0; i < vtx_count[v] && !hit && base + i < ADEPTH; i++) begin
                  if (!arc_written[base + i]) clean = 1'b0;
                  if (arc_label[base + i] == it.letter) begin
                     hit = 1'b1;
                     nxt = arc_dest[base + i];
                  end
               end
               if (hit) v = nxt;
               else dead = 1'b1;
            end
            if (it.word_end) begin
               has_rsp = 1'b1;
               if (!dead) begin
                  if (!vtx_written[v]) clean = 1'b0;
                  found = vtx_final[v];
               end
               v = 0;
               started = 1'b0;
               dead = 1'b0;
            end
         end
         MODE_EMPTY: begin
            // root flag, or nothing found on an empty graph; any open walk is dropped
            has_rsp = 1'b1;
            if (graph_size != 0) begin
               if (!vtx_written[graph_size - 1]) clean = 1'b0;
               found = vtx_final[graph_size - 1];
            end
            v = 0;
            started = 1'b0;
            dead = 1'b0;
         end
         default: ;
      endcase
      if (commit) begin
         walk_vertex = v;
         walk_started = started;
         walk_dead = dead;
      end
   endfunction

   // a transaction with random content in every field the mode does not use
   function automatic lookup_req_t build(input logic [MODE_W-1:0] mode,
                                         input int unsigned arg0, input int unsigned arg1);
      lookup_req_t it;
      it.mode             = mode;
      it.vertex_total     = TOTAL_W'($urandom);
      it.vertex_is_final  = 1'($urandom);
      it.vertex_arc_count = COUNT_W'($urandom);
      it.arc_letter       = CHAR_W'($urandom);
      it.arc_target       = TARGET_W'($urandom);
      it.letter           = CHAR_W'($urandom);
      it.word_end         = 1'($urandom);
      case (mode)
         MODE_BEGIN: it.vertex_total = TOTAL_W'(arg0);
         MODE_VERTEX: begin
            it.vertex_is_final  = arg0[0];
            it.vertex_arc_count = COUNT_W'(arg1);
         end
         MODE_ARC: begin
            it.arc_letter = CHAR_W'(arg0);
            it.arc_target = TARGET_W'(arg1);
         end
         MODE_QUERY: begin
            it.letter   = CHAR_W'(arg0);
            it.word_end = arg1[0];
         end
         default: ;
      endcase
      return it;
   endfunction

   // stray transactions: empty word, lone query letter or an ignored mode
   function automatic lookup_req_t noise_item();
      lookup_req_t it;
      case ($urandom_range(3))
         0: it = build(MODE_EMPTY, 0, 0);
         1: it = build(MODE_QUERY, $urandom, $urandom_range(1));
         default: it = build(MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), 0, 0);
      endcase
      return it;
   endfunction

   // small alphabet with both extremes, so that arcs and query letters often meet
   function automatic bit [CHAR_W-1:0] pick_letter();
      bit [CHAR_W-1:0] alpha [8] = '{8'h00, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h5A, 8'h80, 8'h7F};
      if ($urandom_range(9) < 8) return alpha[$urandom_range(7)];
      return CHAR_W'($urandom);
   endfunction

   // mostly a letter that the current vertex has an arc for, so walks go deep
   function automatic bit [CHAR_W-1:0] next_letter();
      int unsigned v, idx;
      if (graph_size == 0 || walk_dead || $urandom_range(4) == 0) return pick_letter();
      v = walk_started ? walk_vertex : graph_size - 1;
      if (!vtx_written[v] || vtx_count[v] == 0) return pick_letter();
      idx = vtx_first[v] + $urandom_range(vtx_count[v] - 1);
      if (idx < ADEPTH && arc_written[idx]) return arc_label[idx];
      return pick_letter();
   endfunction

   task automatic drive_fields(input lookup_req_t it);
      req_if.mode             <= it.mode;
      req_if.vertex_total     <= it.vertex_total;
      req_if.vertex_is_final  <= it.vertex_is_final;
      req_if.vertex_arc_count <= it.vertex_arc_count;
      req_if.arc_letter       <= it.arc_letter;
      req_if.arc_target       <= it.arc_target;
      req_if.letter           <= it.letter;
      req_if.word_end         <= it.word_end;
   endtask

   // send one transaction after a random gap, then record what it should answer
   task automatic push_item(input lookup_req_t it, input check_kind_t chk, input bit exp);
      bit has_rsp, found, clean;
      while ($urandom_range(99) < src_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      drive_fields(it);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      graph_step(it, 1'b1, has_rsp, found, clean);
      if (has_rsp) pending_found.push_back((chk == CHK_FIXED) ? exp : found);
      if (it.mode <= MODE_EMPTY) items_sent++;
   endtask

   // random traffic only goes out if it reads no table entry that was never written
   task automatic offer_item(input lookup_req_t it);
      bit has_rsp, found, clean;
      graph_step(it, 1'b0, has_rsp, found, clean);
      if (clean) push_item(it, CHK_PREDICT, 1'b0);
   endtask

   // sender holds off until every expected response has come back
   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_found.size() != 0) @(posedge clock);
   endtask

   // words of random length, with stray transactions and empty words mixed in
   task automatic query_words(input int unsigned words);
      int unsigned w, k, len;
      for (w = 0; w < words; w++) begin
         if ($urandom_range(7) == 0) offer_item(build(MODE_EMPTY, 0, 0));
         else begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
               if ($urandom_range(15) == 0) offer_item(noise_item());
               offer_item(build(MODE_QUERY, next_letter(), (k == len - 1)));
            end
         end
      end
   endtask

   // one small graph: begin, vertices, arcs, then words; some loads are left broken
   task automatic graph_session();
      int unsigned n, n_load, total_arcs, n_arcs, cnt, i;
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 10);
      offer_item(build(MODE_BEGIN, n, 0));
      // occasionally one vertex short (stale root) or a couple past the count
      n_load = n;
      case ($urandom_range(11))
         0: n_load = n - 1;
         1: n_load = n + 2;
         default: ;
      endcase
      total_arcs = 0;
      for (i = 0; i < n_load; i++) begin
         cnt = $urandom_range(0, 5);
         // now and then a wide root, up to 256 arcs
         if (i == n - 1 && $urandom_range(7) == 0)
            cnt = $urandom_range(1) ? 256 : $urandom_range(64, 255);
         total_arcs += cnt;
         offer_item(build(MODE_VERTEX, $urandom_range(1), cnt));
         if ($urandom_range(19) == 0) offer_item(noise_item());
      end
      // occasionally a truncated arc list
      n_arcs = total_arcs;
      if (n_arcs != 0 && $urandom_range(9) == 0) n_arcs = $urandom_range(0, n_arcs - 1);
      for (i = 0; i < n_arcs; i++)
         offer_item(build(MODE_ARC, pick_letter(), $urandom_range(n - 1)));
      query_words($urandom_range(3, 10));
   endtask

   // receiver: random stalls at the rate of the current phase
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= snk_stall);
      end
   end

   // response checker: every response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_found.size() == 0) begin
            $error("unexpected response transaction, word_found %0d", rsp_if.word_found);
            errors++;
         end else begin
            if (rsp_if.word_found !== pending_found[0]) begin
               $error("word_found mismatch: expected %0d, actual %0d",
                      pending_found[0], rsp_if.word_found);
               errors++;
            end
            void'(pending_found.pop_front());
         end
      end
   end

   // watchdog: too long without any transaction ends the run
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      int unsigned i, ph;
      lookup_req_t zero_item;
      zero_item = '0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      drive_fields(zero_item);
      src_idle = 0;
      snk_stall = 0;
      errors = 0;
      items_sent = 0;

      // directed rows; fixed answers only where they are obvious
      dir_tab = '{
         '{MODE_EMPTY,     0,     0, CHK_FIXED,   1'b0},  // empty graph has no root
         '{MODE_QUERY,     8'hFF, 1, CHK_FIXED,   1'b0},  // letter on an empty graph
         '{MODE_BEGIN,     3,     0, CHK_PREDICT, 1'b0},
         '{MODE_VERTEX,    1,     0, CHK_PREDICT, 1'b0},  // v0: final, no arcs
         '{MODE_VERTEX,    0,     2, CHK_PREDICT, 1'b0},  // v1: two arcs
         '{MODE_VERTEX,    1,     2, CHK_PREDICT, 1'b0},  // v2: root, two arcs
         '{MODE_ARC,       8'h00, 0, CHK_PREDICT, 1'b0},  // v1 arcs
         '{MODE_ARC,       8'hFF, 0, CHK_PREDICT, 1'b0},
         '{MODE_ARC,       8'h41, 1, CHK_PREDICT, 1'b0},  // root arcs
         '{MODE_ARC,       8'h00, 0, CHK_PREDICT, 1'b0},
         '{MODE_EMPTY,     0,     0, CHK_FIXED,   1'b1},  // root is final
         '{MODE_QUERY,     8'h41, 0, CHK_PREDICT, 1'b0},  // two-letter word
         '{MODE_QUERY,     8'hFF, 1, CHK_PREDICT, 1'b0},
         '{MODE_QUERY,     8'h00, 1, CHK_PREDICT, 1'b0},  // second arc of the root
         '{MODE_QUERY,     8'h41, 1, CHK_PREDICT, 1'b0},  // ends on a non-final vertex
         '{MODE_QUERY,     8'h7F, 0, CHK_PREDICT, 1'b0},  // no arc: walk goes dead
         '{MODE_QUERY,     8'h41, 1, CHK_FIXED,   1'b0},  // dead walk answers not found
         '{MODE_QUERY,     8'h41, 0, CHK_PREDICT, 1'b0},  // open a walk
         '{MODE_EMPTY,     0,     0, CHK_FIXED,   1'b1},  // empty word drops it
         '{MODE_QUERY,     8'h00, 1, CHK_PREDICT, 1'b0},  // fresh walk from the root
         '{MODE_UNUSED_LO, 0,     0, CHK_PREDICT, 1'b0},  // ignored modes
         '{MODE_UNUSED_HI, 0,     0, CHK_PREDICT, 1'b0},
         '{MODE_BEGIN,     0,     0, CHK_PREDICT, 1'b0},  // graph of size zero
         '{MODE_EMPTY,     0,     0, CHK_FIXED,   1'b0}
      };

      // reset, once, before the directed rows
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_N; i++)
         push_item(build(dir_tab[i].mode, dir_tab[i].arg0, dir_tab[i].arg1),
                   dir_tab[i].chk, dir_tab[i].exp);
      pause_until_drained();

      // fill both tables past capacity: the vertex total saturates, vertex 0 has three
      // arcs and the rest two, so the root's arcs straddle the end of the arc table and
      // the layout offset saturates; the extra vertices and arcs are dropped
      offer_item(build(MODE_BEGIN, 8191, 0));
      for (i = 0; i < VDEPTH + 4; i++)
         offer_item(build(MODE_VERTEX, $urandom_range(1),
                          (i == 0) ? 3 : ((i >= VDEPTH) ? 256 : 2)));
      for (i = 0; i < ADEPTH + 3; i++)
         offer_item(build(MODE_ARC, (i == 0) ? 8'hFF : pick_letter(),
                          (i == 0) ? VDEPTH - 1 : $urandom_range(VDEPTH - 1)));
      query_words(60);
      pause_until_drained();

      // random graphs under each idling pattern, draining between patterns
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin src_idle = 0;  snk_stall = 0;  end
            1: begin src_idle = 60; snk_stall = 0;  end
            2: begin src_idle = 0;  snk_stall = 60; end
            default: begin src_idle = 37; snk_stall = 37; end
         endcase
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) graph_session();
         pause_until_drained();
      end

      // let any last scan settle before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_found.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/dwl_pkg.sv
sv/dwl_if.sv
sv/dwl_vtx_ram.sv
sv/dwl_arc_scan.sv
sv/dawg_word_lookup.sv
tb/dawg_word_lookup_tb.sv
